// File: hdl/fdrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdrl_pkg;

   // Fixed field widths
   localparam int IdWidth    = 32;
   localparam int CountWidth = 5;
   localparam int CfgWidth   = 5;

   // Parameter defaults
   localparam int CapacityDefault = 16;
   localparam int IdBitsDefault   = 32;

   // Capacity register value after reset
   localparam logic [CfgWidth-1:0] CapacityReset = 5'd16;

   // Depth of the queue between front and back
   localparam int QueueDepth = 2;

   // Command codes
   localparam logic CmdMessage = 1'b0;
   localparam logic CmdReadout = 1'b1;

   // Result kind codes
   localparam logic KindStatus = 1'b0;
   localparam logic KindEntry  = 1'b1;

   typedef struct packed {
      logic               command;
      logic [IdWidth-1:0] visitor_id;
   } fdrl_item_type;

endpackage

`default_nettype wire

// File: hdl/fdrl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fdrl_front #(
   parameter int ID_BITS = fdrl_pkg::IdBitsDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_command,
   input  wire logic [fdrl_pkg::IdWidth-1:0] req_visitor_id,
   output logic                             item_valid,
   output fdrl_pkg::fdrl_item_type          item,
   input  wire logic                        item_pop
);
   import fdrl_pkg::*;

   localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntW = $clog2(QueueDepth + 1);
   localparam logic [IdWidth-1:0] IdMask =
      (ID_BITS >= IdWidth) ? {IdWidth{1'b1}} : IdWidth'((64'd1 << ID_BITS) - 64'd1);

   fdrl_item_type      q_ff [QueueDepth];
   fdrl_item_type      item_in;
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   cnt_ff, cnt_in;
   logic               push;

   // classify: decode command, mask id to the configured width
   always_comb begin
      item_in.command    = req_command;
      item_in.visitor_id = req_visitor_id & IdMask;
   end

   assign req_ready  = (cnt_ff != QCntW'(QueueDepth));
   assign push       = req_valid && req_ready;
   assign item_valid = (cnt_ff != '0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !item_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (item_pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (cnt_ff != '0))
      else $error("queue popped while empty");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCntW'(QueueDepth))
      else $error("queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

// File: hdl/fdrl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fdrl_back #(
   parameter int CAPACITY = fdrl_pkg::CapacityDefault,
   parameter int ID_BITS  = fdrl_pkg::IdBitsDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [fdrl_pkg::CfgWidth-1:0]   csr_wdata,
   input  wire logic                           item_valid,
   input  wire fdrl_pkg::fdrl_item_type        item,
   output logic                                item_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_kind,
   output logic                                rsp_hit,
   output logic                                rsp_evicted,
   output logic [fdrl_pkg::IdWidth-1:0]        rsp_entry_id,
   output logic                                rsp_entry_valid,
   output logic [fdrl_pkg::CountWidth-1:0]     rsp_held_count,
   output logic                                rsp_last
);
   import fdrl_pkg::*;

   localparam int PtrW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OccW   = $clog2(CAPACITY + 1);
   localparam int CmpW   = (OccW > CfgWidth) ? OccW : CfgWidth;
   localparam int SumW   = OccW + 1;
   localparam int StoreW = (ID_BITS < IdWidth) ? ID_BITS : IdWidth;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [StoreW-1:0]  store_ff [CAPACITY];
   logic [PtrW-1:0]    oldest_ff, oldest_in;
   logic [OccW-1:0]    occ_ff, occ_in;
   logic [PtrW-1:0]    pos_ff, pos_in;
   logic [OccW-1:0]    rem_ff, rem_in;
   logic [CfgWidth-1:0] cap_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_evicted_ff, rsp_evicted_in;
   logic [IdWidth-1:0] rsp_entry_id_ff, rsp_entry_id_in;
   logic               rsp_entry_valid_ff, rsp_entry_valid_in;
   logic [CountWidth-1:0] rsp_held_count_ff, rsp_held_count_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [StoreW-1:0]  id_t;
   logic [CAPACITY-1:0] held, match;
   logic               hit;
   logic [CmpW-1:0]    cap_ext, eff_cap;
   logic               full;
   logic [SumW-1:0]    sum_wr, sum_new;
   logic [PtrW-1:0]    wr_idx, newest, oldest_next, pos_prev, rd_addr;
   logic [StoreW-1:0]  rd_data;
   logic               store_we;
   logic               load;

   assign id_t = item.visitor_id[StoreW-1:0];

   // Parallel compare against every held entry
   always_comb begin
      logic [SumW-1:0] rel;
      logic [SumW-1:0] idx;
      for (int i = 0; i < CAPACITY; i++) begin
         idx = SumW'(i);
         rel = (idx >= SumW'(oldest_ff)) ? idx - SumW'(oldest_ff)
                                         : idx + SumW'(CAPACITY) - SumW'(oldest_ff);
         held[i]  = (rel < SumW'(occ_ff));
         match[i] = (store_ff[i] == id_t);
      end
   end

   assign hit = |(held & match);

   // Effective capacity: 0 acts as 1, clamp to CAPACITY
   assign cap_ext = CmpW'(cap_ff);
   assign eff_cap = (cap_ff == '0) ? CmpW'(1)
                  : ((cap_ext > CmpW'(CAPACITY)) ? CmpW'(CAPACITY) : cap_ext);
   assign full    = (CmpW'(occ_ff) >= eff_cap);

   // Ring positions: insert slot, newest slot, neighbors
   assign sum_wr  = SumW'(oldest_ff) + SumW'(occ_ff);
   assign wr_idx  = (sum_wr >= SumW'(CAPACITY)) ? PtrW'(sum_wr - SumW'(CAPACITY))
                                                : PtrW'(sum_wr);
   assign sum_new = sum_wr - SumW'(1);
   assign newest  = (sum_new >= SumW'(CAPACITY)) ? PtrW'(sum_new - SumW'(CAPACITY))
                                                 : PtrW'(sum_new);
   assign oldest_next = (oldest_ff == PtrW'(CAPACITY - 1)) ? '0 : oldest_ff + 1'b1;
   assign pos_prev    = (pos_ff == '0) ? PtrW'(CAPACITY - 1) : pos_ff - 1'b1;

   // Single read port: oldest slot for eviction, walk position for readout
   assign rd_addr = (state_ff == ST_READ) ? pos_ff : oldest_ff;
   assign rd_data = store_ff[rd_addr];

   assign load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in           = state_ff;
      oldest_in          = oldest_ff;
      occ_in             = occ_ff;
      pos_in             = pos_ff;
      rem_in             = rem_ff;
      store_we           = 1'b0;
      item_pop           = 1'b0;
      rsp_valid_in       = rsp_valid_ff;
      rsp_kind_in        = rsp_kind_ff;
      rsp_hit_in         = rsp_hit_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_entry_id_in    = rsp_entry_id_ff;
      rsp_entry_valid_in = rsp_entry_valid_ff;
      rsp_held_count_in  = rsp_held_count_ff;
      rsp_last_in        = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  item_pop = 1'b1;
                  if (item.command == CmdMessage) begin
                     if (!hit) begin
                        store_we = 1'b1;
                        if (full) begin
                           oldest_in = oldest_next;
                        end else begin
                           occ_in = occ_ff + 1'b1;
                        end
                     end
                     rsp_valid_in       = 1'b1;
                     rsp_kind_in        = KindStatus;
                     rsp_hit_in         = hit;
                     rsp_evicted_in     = !hit && full;
                     rsp_entry_id_in    = (!hit && full) ? IdWidth'(rd_data) : '0;
                     rsp_entry_valid_in = !hit && full;
                     rsp_held_count_in  = CountWidth'(occ_in);
                     rsp_last_in        = 1'b1;
                  end else if (occ_ff == '0) begin
                     rsp_valid_in       = 1'b1;
                     rsp_kind_in        = KindEntry;
                     rsp_hit_in         = 1'b0;
                     rsp_evicted_in     = 1'b0;
                     rsp_entry_id_in    = '0;
                     rsp_entry_valid_in = 1'b0;
                     rsp_held_count_in  = '0;
                     rsp_last_in        = 1'b1;
                  end else begin
                     state_in = ST_READ;
                     pos_in   = newest;
                     rem_in   = occ_ff;
                  end
               end
            end
            ST_READ: begin
               rsp_valid_in       = 1'b1;
               rsp_kind_in        = KindEntry;
               rsp_hit_in         = 1'b0;
               rsp_evicted_in     = 1'b0;
               rsp_entry_id_in    = IdWidth'(rd_data);
               rsp_entry_valid_in = 1'b1;
               rsp_held_count_in  = CountWidth'(occ_ff);
               rsp_last_in        = (rem_ff == OccW'(1));
               rem_in             = rem_ff - 1'b1;
               pos_in             = pos_prev;
               if (rem_ff == OccW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         occ_ff       <= '0;
         pos_ff       <= '0;
         rem_ff       <= '0;
         cap_ff       <= CapacityReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         occ_ff       <= occ_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff        <= rsp_kind_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_entry_id_ff    <= rsp_entry_id_in;
      rsp_entry_valid_ff <= rsp_entry_valid_in;
      rsp_held_count_ff  <= rsp_held_count_in;
      rsp_last_ff        <= rsp_last_in;
      if (store_we) begin
         store_ff[wr_idx] <= id_t;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_entry_id    = rsp_entry_id_ff;
   assign rsp_entry_valid = rsp_entry_valid_ff;
   assign rsp_held_count  = rsp_held_count_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OccW'(CAPACITY))
      else $error("occupancy above capacity");

   a_oldest_range: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= PtrW'(CAPACITY - 1))
      else $error("oldest pointer out of ring");

   a_read_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rem_ff != '0))
      else $error("readout walk with nothing left");

   a_evict_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KindStatus && rsp_evicted_ff)
         |-> (rsp_entry_valid_ff && !rsp_hit_ff))
      else $error("eviction flags inconsistent");
`endif

endmodule

`default_nettype wire

// File: hdl/fifo_dedup_recent_list.sv
// Message item: result through the front queue and the result register; one message
//   per cycle sustained while rsp_ready is high. Readout item: walk state entered first,
//   then one entry per cycle while rsp_ready is high (one closing result when empty);
//   bound by the single read port of the id ring, walked newest to oldest.
// Synchronous active-high reset: list empty, oldest pointer 0, capacity 16,
//   queue and output register empty. Id ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module fifo_dedup_recent_list #(
   parameter int CAPACITY = fdrl_pkg::CapacityDefault,
   parameter int ID_BITS  = fdrl_pkg::IdBitsDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_we,
   input  wire logic [fdrl_pkg::CfgWidth-1:0]   csr_wdata,
   // request items
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_command,
   input  wire logic [fdrl_pkg::IdWidth-1:0]    req_visitor_id,
   // result items
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_kind,
   output logic                                rsp_hit,
   output logic                                rsp_evicted,
   output logic [fdrl_pkg::IdWidth-1:0]        rsp_entry_id,
   output logic                                rsp_entry_valid,
   output logic [fdrl_pkg::CountWidth-1:0]     rsp_held_count,
   output logic                                rsp_last
);
   import fdrl_pkg::*;

   // front -> back item path
   fdrl_item_type item;
   logic          item_valid;
   logic          item_pop;

   // Front: accepts items, masks the id, buffers them in a short queue
   fdrl_front #(
      .ID_BITS (ID_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_visitor_id (req_visitor_id),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   // Back: id ring with parallel hit check, FIFO replacement, readout walker,
   // and the registered result stage
   fdrl_back #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_hit         (rsp_hit),
      .rsp_evicted     (rsp_evicted),
      .rsp_entry_id    (rsp_entry_id),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_held_count  (rsp_held_count),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: dv/fifo_dedup_recent_list_test.sv
`timescale 1ns / 1ps

module fifo_dedup_recent_list_test;
   import fdrl_pkg::*;

   // Ring depth of the instance under test (default parameters).
   localparam int ListDepth = CapacityDefault;
   // Idle cycles to let pass before a capacity write or after a drain pause;
   // covers the front queue and result register with margin.
   localparam int SettleCycles = 6;
   // Random phases, one capacity setting each.
   localparam int PhaseCount = 10;
   localparam int PhaseItems = 44;

   // One result item as the block presents it.
   typedef struct packed {
      logic                  kind;
      logic                  hit;
      logic                  evicted;
      logic [IdWidth-1:0]    entry_id;
      logic                  entry_valid;
      logic [CountWidth-1:0] held_count;
      logic                  last;
   } list_result_type;

   // What the driver does next: send an item, write capacity, or wait idle.
   typedef enum logic [1:0] {StepItem, StepCap, StepDrain} step_op_type;

   typedef struct {
      step_op_type        op;
      logic               command;
      logic [IdWidth-1:0] id;
      logic [CfgWidth-1:0] cap;
   } plan_step_type;

   // Clock, reset and every block input start at known values.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CfgWidth-1:0]   csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_command = CmdMessage;
   logic [IdWidth-1:0]    req_visitor_id = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_kind;
   logic                  rsp_hit;
   logic                  rsp_evicted;
   logic [IdWidth-1:0]    rsp_entry_id;
   logic                  rsp_entry_valid;
   logic [CountWidth-1:0] rsp_held_count;
   logic                  rsp_last;

   fifo_dedup_recent_list DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_visitor_id (req_visitor_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_hit        (rsp_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_entry_id   (rsp_entry_id),
      .rsp_entry_valid(rsp_entry_valid),
      .rsp_held_count (rsp_held_count),
      .rsp_last       (rsp_last)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the recent-id list. head is the ring slot of the oldest id,
   // held the number of ids in the list, cap_reg the raw register value.
   // ---------------------------------------------------------------------
   logic [IdWidth-1:0]  ring [ListDepth];
   int                  head = 0;
   int                  held = 0;
   logic [CfgWidth-1:0] cap_reg = CapacityReset;

   plan_step_type   visit_plan[$];   // items and pauses still to be sent
   list_result_type due_results[$];  // results predicted but not yet seen

   // Run statistics for the summary.
   int msg_total = 0, hit_total = 0, evict_total = 0;
   int readout_total = 0, entry_total = 0, cap_writes = 0;
   int fail_count = 0;

   function automatic string fmt_result(input list_result_type r);
      return $sformatf("kind=%0d hit=%0d ev=%0d id=%h vld=%0d cnt=%0d last=%0d",
                       r.kind, r.hit, r.evicted, r.entry_id, r.entry_valid,
                       r.held_count, r.last);
   endfunction

   // Update the shadow list for one accepted item and queue what the block
   // must return for it.
   task automatic predict_list_results(input logic cmd, input logic [IdWidth-1:0] id);
      int              limit;
      bit              hit;
      list_result_type r;
      r = '0;
      if (cmd == CmdMessage) begin
         msg_total++;
         // Out-of-range capacity: 0 behaves as 1, anything above depth as depth.
         limit = (cap_reg == 0) ? 1 : (cap_reg > ListDepth) ? ListDepth : int'(cap_reg);
         hit = 1'b0;
         for (int i = 0; i < held; i++) begin
            if (ring[(head + i) % ListDepth] == id) hit = 1'b1;
         end
         r.kind = KindStatus;
         r.hit = hit;
         if (!hit) begin
            if (held >= limit) begin
               // Full (or over a lowered capacity): drop exactly one oldest id,
               // occupancy does not change.
               r.evicted = 1'b1;
               r.entry_valid = 1'b1;
               r.entry_id = ring[head];
               head = (head + 1) % ListDepth;
               ring[(head + held - 1) % ListDepth] = id;
               evict_total++;
            end else begin
               ring[(head + held) % ListDepth] = id;
               held++;
            end
         end else begin
            hit_total++;
         end
         r.held_count = CountWidth'(held);
         r.last = 1'b1;
         due_results.insert(due_results.size(), r);
      end else begin
         readout_total++;
         r.kind = KindEntry;
         if (held == 0) begin
            // Empty list: a single closing result with nothing in it.
            r.last = 1'b1;
            due_results.insert(due_results.size(), r);
         end else begin
            // Newest first, last flag on the oldest.
            for (int i = 0; i < held; i++) begin
               r.entry_id = ring[(head + held - 1 - i) % ListDepth];
               r.entry_valid = 1'b1;
               r.held_count = CountWidth'(held);
               r.last = (i + 1 == held);
               due_results.insert(due_results.size(), r);
               entry_total++;
            end
         end
      end
   endtask

   task automatic plan_item(input logic cmd, input logic [IdWidth-1:0] id);
      plan_step_type s;
      s.op = StepItem;
      s.command = cmd;
      s.id = id;
      s.cap = '0;
      visit_plan.insert(visit_plan.size(), s);
   endtask

   task automatic plan_cap(input logic [CfgWidth-1:0] value);
      plan_step_type s;
      s.op = StepCap;
      s.command = CmdMessage;
      s.id = '0;
      s.cap = value;
      visit_plan.insert(visit_plan.size(), s);
   endtask

   // ---------------------------------------------------------------------
   // Driver. Sends items in bursts with random gaps. Capacity writes and
   // drain pauses wait until no item is in flight, no result is due, and
   // SettleCycles quiet cycles have passed.
   // ---------------------------------------------------------------------
   int            burst_left = 0;
   int            gap_left = 0;
   int            quiet_left = SettleCycles;
   logic          next_valid;
   logic          next_we;
   plan_step_type step;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_we <= 1'b0;
         burst_left = 0;
         gap_left = 0;
         quiet_left = SettleCycles;
      end else begin
         next_valid = req_valid;
         next_we = 1'b0;
         if (req_valid && req_ready) begin
            predict_list_results(req_command, req_visitor_id);
            next_valid = 1'b0;
         end
         if (!next_valid && visit_plan.size() > 0) begin
            step = visit_plan[0];
            if (step.op == StepItem) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  void'(visit_plan.pop_front());
                  req_command <= step.command;
                  req_visitor_id <= step.id;
                  next_valid = 1'b1;
                  if (burst_left == 0) burst_left = $urandom_range(1, 24);
                  burst_left--;
                  // About a quarter of the bursts run straight into the next.
                  if (burst_left == 0)
                     gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else if (req_valid || due_results.size() != 0) begin
               quiet_left = SettleCycles;
            end else if (quiet_left > 0) begin
               quiet_left--;
            end else begin
               if (step.op == StepCap) begin
                  // Takes effect at the next edge; no item can be accepted
                  // before then.
                  next_we = 1'b1;
                  csr_wdata <= step.cap;
                  cap_reg = step.cap;
                  cap_writes++;
               end
               void'(visit_plan.pop_front());
               quiet_left = SettleCycles;
            end
         end
         req_valid <= next_valid;
         csr_we <= next_we;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor and receiver. Checks each accepted result against the oldest
   // prediction; ready follows modes of its own: always ready, random
   // stalls, or long alternating stall/ready runs.
   // ---------------------------------------------------------------------
   int              rx_mode = 0;
   int              rx_mode_left = 0;
   int              rx_run_left = 0;
   logic            rx_level = 1'b1;
   logic            next_ready;
   list_result_type got;
   list_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_hit, rsp_evicted, rsp_entry_id, rsp_entry_valid,
                   rsp_held_count, rsp_last};
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with none due: %s", $time, fmt_result(got));
            end else begin
               want = due_results.pop_front();
               if (got.kind !== want.kind || got.hit !== want.hit ||
                   got.evicted !== want.evicted || got.entry_id !== want.entry_id ||
                   got.entry_valid !== want.entry_valid ||
                   got.held_count !== want.held_count || got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch expected %s", $time, fmt_result(want));
                     $display("%0t:          actual   %s", $time, fmt_result(got));
                  end
               end
            end
         end
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 80);
         end
         rx_mode_left--;
         case (rx_mode)
            0: begin
               next_ready = 1'b1;
            end
            1: begin
               next_ready = ($urandom_range(0, 3) != 0);
            end
            default: begin
               if (rx_run_left == 0) begin
                  rx_level = !rx_level;
                  rx_run_left = rx_level ? $urandom_range(1, 4) : $urandom_range(1, 10);
               end
               rx_run_left--;
               next_ready = rx_level;
            end
         endcase
         rsp_ready <= next_ready;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus plan, reset, and end of run.
   // ---------------------------------------------------------------------
   logic [CfgWidth-1:0] cap_walk [PhaseCount];
   logic [IdWidth-1:0]  id_pool[$];
   logic [IdWidth-1:0]  pick;
   int                  eff_cap;
   int                  pool_size;
   int                  roll;

   initial begin
      // Directed: empty readout, id extremes, a hit, then capacity 0 (acts
      // as 1) below the current occupancy so insertions evict without
      // shrinking, then capacity 31 (acts as 16) and a full list with
      // wrap-around eviction and a full-length readout.
      plan_item(CmdReadout, 32'h0000_0000);
      plan_item(CmdMessage, 32'h0000_0000);
      plan_item(CmdMessage, 32'hFFFF_FFFF);
      plan_item(CmdMessage, 32'h0000_0000);
      plan_item(CmdReadout, 32'hFFFF_FFFF);
      plan_cap(5'd0);
      plan_item(CmdMessage, 32'hFFFF_FFFF);
      plan_item(CmdMessage, 32'h1234_5678);
      plan_item(CmdReadout, $urandom);
      plan_cap(5'h1F);
      for (int k = 0; k < 15; k++) plan_item(CmdMessage, 32'hA5A5_0000 + k);
      plan_item(CmdReadout, $urandom);

      // Random phases: mostly ids from a small pool just over the capacity
      // so hits and evictions both happen, plus fresh and extreme ids and
      // readouts. One idle drain per phase.
      cap_walk = '{5'd1, 5'd16, 5'd2, 5'd5, 5'd0, 5'd31, 5'd8, 5'd3, 5'd17, 5'd12};
      cap_walk[PhaseCount - 1] = CfgWidth'($urandom_range(0, 31));
      for (int p = 0; p < PhaseCount; p++) begin
         plan_cap(cap_walk[p]);
         eff_cap = (cap_walk[p] == 0) ? 1 :
                   (cap_walk[p] > ListDepth) ? ListDepth : int'(cap_walk[p]);
         id_pool.delete();
         pool_size = eff_cap + int'($urandom_range(1, 4));
         for (int k = 0; k < pool_size; k++) id_pool.insert(id_pool.size(), $urandom);
         for (int n = 0; n < PhaseItems; n++) begin
            if (n == PhaseItems / 2) begin
               step.op = StepDrain;
               step.command = CmdMessage;
               step.id = '0;
               step.cap = '0;
               visit_plan.insert(visit_plan.size(), step);
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               plan_item(CmdReadout, $urandom);
            end else begin
               if (roll < 75) pick = id_pool[$urandom_range(0, id_pool.size() - 1)];
               else if (roll < 90) pick = $urandom;
               else case ($urandom_range(0, 3))
                  0: pick = 32'h0000_0000;
                  1: pick = 32'hFFFF_FFFF;
                  2: pick = 32'h1 << $urandom_range(0, 31);
                  default: pick = ~(32'h1 << $urandom_range(0, 31));
               endcase
               plan_item(CmdMessage, pick);
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge so the driver's updates at the rising
      // edge have settled.
      do @(negedge clock);
      while (visit_plan.size() != 0 || req_valid || due_results.size() != 0);
      repeat (20) @(posedge clock);

      $display("Sent %0d messages (%0d hits, %0d evictions) and %0d readouts (%0d entries)",
               msg_total, hit_total, evict_total, readout_total, entry_total);
      $display("over %0d capacity writes; %0d failing results.", cap_writes, fail_count);
      if (fail_count == 0)
         $display("** fifo_dedup_recent_list: PASSED **");
      else
         $display("** fifo_dedup_recent_list: FAILED **");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Timeout with %0d items and %0d results outstanding",
               visit_plan.size(), due_results.size());
      $display("** fifo_dedup_recent_list: FAILED **");
      $finish;
   end

endmodule
